// ===== hw/rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants, the lane record and the arctangent table used
// by the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // Default number of CORDIC rotation cells.
  localparam int CORDIC_STAGES_DEF = 16;

  // Quaternion component after the sign fold (holds +32768).
  localparam int QW = 17;
  // Exact product of two folded components.
  localparam int PW = 34;
  // Doubled sums, numerators and denominators in Q28.
  localparam int NW = 36;
  // Clamped asin argument in Q28.
  localparam int SW = 30;
  // Square root: one result bit per cell, radicand and partial root widths.
  localparam int SQ_STEPS = 29;
  localparam int VW = 57;
  localparam int RW = 58;
  // CORDIC lane datapath and angle widths.
  localparam int LW = 44;
  localparam int AW = 28;
  // Normalizer: six shift cells, shifted magnitude stays below 2^41.
  localparam int NRM_STEPS = 6;
  localparam int NORM_TOP = 41;
  // Scaled angle width (degrees with 16 fraction bits times 100).
  localparam int MW = 36;

  localparam logic signed [NW-1:0] Q28_ONE = 36'sd268435456;
  localparam logic [2*SW-1:0] Q56_ONE = 60'd1 << 56;
  localparam logic signed [AW-1:0] DEG180 = 28'sd11796480;
  localparam logic signed [AW-1:0] DEG360 = 28'sd23592960;

  // One atan2 in flight: rotated vector, accumulated angle, quadrant base,
  // and a flag for operands that resolve without rotation.
  typedef struct packed {
    logic signed [LW-1:0] x;
    logic signed [LW-1:0] y;
    logic [LW-1:0]        mor;
    logic signed [AW-1:0] z;
    logic signed [AW-1:0] base;
    logic                 done;
  } lane_t;

  // atan(2^-i) in degrees with 16 fraction bits.
  function automatic logic signed [AW-1:0] atan_deg(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0:  r = 28'sd2949120;
      1:  r = 28'sd1740967;
      2:  r = 28'sd919879;
      3:  r = 28'sd466945;
      4:  r = 28'sd234379;
      5:  r = 28'sd117304;
      6:  r = 28'sd58666;
      7:  r = 28'sd29335;
      8:  r = 28'sd14668;
      9:  r = 28'sd7334;
      10: r = 28'sd3667;
      11: r = 28'sd1833;
      12: r = 28'sd917;
      13: r = 28'sd458;
      14: r = 28'sd229;
      15: r = 28'sd115;
      16: r = 28'sd57;
      17: r = 28'sd29;
      18: r = 28'sd14;
      19: r = 28'sd7;
      20: r = 28'sd4;
      21: r = 28'sd2;
      22: r = 28'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/q2e_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One step of the digit-by-digit integer square root: settles one root bit
// and hands the remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [q2e_pkg::VW-1:0]   v_in,
  input  logic [q2e_pkg::RW-1:0]   r_in,
  output logic [q2e_pkg::VW-1:0]   v_out,
  output logic [q2e_pkg::RW-1:0]   r_out
);
  import q2e_pkg::*;

  localparam logic [RW:0] BIT = (RW+1)'(1) << (2*STEP);

  logic [RW:0]   trial;
  logic [VW-1:0] v_next;
  logic [RW-1:0] r_next;

  // Subtract the trial value when it fits and set this root bit.
  always_comb begin
    trial = {1'b0, r_in} + BIT;
    if ({2'b00, v_in} >= trial) begin
      v_next = v_in - trial[VW-1:0];
      r_next = (r_in >> 1) + BIT[RW-1:0];
    end else begin
      v_next = v_in;
      r_next = r_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= v_next;
      r_out <= r_next;
    end
  end

endmodule

// ===== hw/rtl/q2e_norm_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_norm_cell
// One step of the operand normalizer: shifts the vector left by a fixed
// amount when the result still stays below the normalization ceiling.
// ----------------------------------------------------------------------------
module q2e_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic            clk,
  input  logic            en,
  input  q2e_pkg::lane_t  d,
  output q2e_pkg::lane_t  q
);
  import q2e_pkg::*;

  lane_t nxt;

  // Shift only if no set bit of the magnitude would reach the ceiling.
  always_comb begin
    nxt = d;
    if ((d.mor >> (NORM_TOP - SHIFT)) == '0) begin
      nxt.x   = d.x <<< SHIFT;
      nxt.y   = d.y <<< SHIFT;
      nxt.mor = d.mor << SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hw/rtl/q2e_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC rotation: drives y toward zero and accumulates the
// rotation angle for its stage.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            en,
  input  q2e_pkg::lane_t  d,
  output q2e_pkg::lane_t  q
);
  import q2e_pkg::*;

  localparam logic signed [AW-1:0] ANG = atan_deg(STAGE);

  lane_t nxt;

  // Rotate against the sign of y.
  always_comb begin
    nxt = d;
    if (!d.y[LW-1]) begin
      nxt.x = d.x + (d.y >>> STAGE);
      nxt.y = d.y - (d.x >>> STAGE);
      nxt.z = d.z + ANG;
    end else begin
      nxt.x = d.x - (d.y >>> STAGE);
      nxt.y = d.y + (d.x >>> STAGE);
      nxt.z = d.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hw/rtl/quaternion_to_euler_centidegrees_core.sv =====
// Throughput: one quaternion per cycle while the skid entry is empty; every stage is a
// register and the pipe moves as one.
// A two-entry output (result register plus skid) takes up a stalled result before input stalls.
// Reset clears all valid bits, the result and skid valid flags included; data needs no reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_centidegrees_core
// Converts a unit quaternion in Q2.14 to roll, pitch and yaw in centidegrees
// through a product stage, a square root cell chain, a normalizer and three
// lanes of CORDIC cells.
// ----------------------------------------------------------------------------
module quaternion_to_euler_centidegrees_core #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               euler_valid,
  input  logic               euler_stall,
  output logic signed [14:0] roll_cdeg,
  output logic signed [15:0] pitch_cdeg,
  output logic signed [15:0] yaw_cdeg
);
  import q2e_pkg::*;

  localparam int NST = 4 + SQ_STEPS + 1 + NRM_STEPS + CORDIC_STAGES + 3;
  localparam int NL  = 3;   // lane 0 yaw, lane 1 pitch, lane 2 roll

  localparam logic signed [MW-1:0] RND     = 36'sd65535;
  localparam logic signed [MW-1:0] ZERO_M  = 36'sd0;
  localparam logic signed [MW-1:0] CD_180  = 36'sd18000;
  localparam logic signed [MW-1:0] CD_90   = 36'sd9000;
  localparam logic signed [MW-1:0] SCALE   = 36'sd100;

  logic           en;
  logic [NST-1:0] vld;

  // Pipeline valid bits; the whole pipe advances unless the skid entry is full.
  logic           skid_valid;
  assign en         = !skid_valid;
  assign quat_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], quat_valid};
    end
  end

  // Fold the sign of w into all four components.
  logic signed [QW-1:0] w0, x0, y0, z0;
  logic signed [QW-1:0] wi, xi, yi, zi;
  assign wi = QW'(quat_w);
  assign xi = QW'(quat_x);
  assign yi = QW'(quat_y);
  assign zi = QW'(quat_z);

  always_ff @(posedge clk) begin
    if (en) begin
      w0 <= quat_w[15] ? -wi : wi;
      x0 <= quat_w[15] ? -xi : xi;
      y0 <= quat_w[15] ? -yi : yi;
      z0 <= quat_w[15] ? -zi : zi;
    end
  end

  // Exact Q4.28 products.
  logic signed [PW-1:0] p_yw, p_xz, p_xy, p_zw, p_xx, p_yy, p_zz, p_xw, p_yz;

  always_ff @(posedge clk) begin
    if (en) begin
      p_yw <= y0 * w0;
      p_xz <= x0 * z0;
      p_xy <= x0 * y0;
      p_zw <= z0 * w0;
      p_xx <= x0 * x0;
      p_yy <= y0 * y0;
      p_zz <= z0 * z0;
      p_xw <= x0 * w0;
      p_yz <= y0 * z0;
    end
  end

  // Numerators, denominators and the clamped asin argument.
  logic signed [NW-1:0] yn2, yd2, pn2, pd2, st;
  logic signed [SW-1:0] s2, s_clamp;

  always_comb begin
    st = (NW'(p_xw) - NW'(p_yz)) <<< 1;
    if (st > Q28_ONE) begin
      s_clamp = SW'(Q28_ONE);
    end else if (st < -Q28_ONE) begin
      s_clamp = SW'(-Q28_ONE);
    end else begin
      s_clamp = SW'(st);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yn2 <= (NW'(p_yw) + NW'(p_xz)) <<< 1;
      yd2 <= Q28_ONE - ((NW'(p_yy) + NW'(p_xx)) <<< 1);
      pn2 <= (NW'(p_xy) + NW'(p_zw)) <<< 1;
      pd2 <= Q28_ONE - ((NW'(p_xx) + NW'(p_zz)) <<< 1);
      s2  <= s_clamp;
    end
  end

  // Radicand 1 - s^2 in Q56.
  logic signed [2*SW-1:0] ssq;
  logic [2*SW-1:0]        rad;
  logic [VW-1:0]          v3;
  logic signed [NW-1:0]   yn3, yd3, pn3, pd3;
  logic signed [SW-1:0]   s3;

  assign ssq = s2 * s2;
  assign rad = Q56_ONE - $unsigned(ssq);

  always_ff @(posedge clk) begin
    if (en) begin
      v3  <= rad[VW-1:0];
      yn3 <= yn2;
      yd3 <= yd2;
      pn3 <= pn2;
      pd3 <= pd2;
      s3  <= s2;
    end
  end

  // Square root cell chain, with the other operands carried alongside.
  logic [VW-1:0]        sq_v  [SQ_STEPS];
  logic [RW-1:0]        sq_r  [SQ_STEPS];
  logic signed [NW-1:0] sq_yn [SQ_STEPS];
  logic signed [NW-1:0] sq_yd [SQ_STEPS];
  logic signed [NW-1:0] sq_pn [SQ_STEPS];
  logic signed [NW-1:0] sq_pd [SQ_STEPS];
  logic signed [SW-1:0] sq_s  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      q2e_sqrt_cell #(.STEP(SQ_STEPS-1)) u_cell (
        .clk(clk), .en(en), .v_in(v3), .r_in('0),
        .v_out(sq_v[k]), .r_out(sq_r[k])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          sq_yn[k] <= yn3;
          sq_yd[k] <= yd3;
          sq_pn[k] <= pn3;
          sq_pd[k] <= pd3;
          sq_s[k]  <= s3;
        end
      end
    end else begin : g_rest
      q2e_sqrt_cell #(.STEP(SQ_STEPS-1-k)) u_cell (
        .clk(clk), .en(en), .v_in(sq_v[k-1]), .r_in(sq_r[k-1]),
        .v_out(sq_v[k]), .r_out(sq_r[k])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          sq_yn[k] <= sq_yn[k-1];
          sq_yd[k] <= sq_yd[k-1];
          sq_pn[k] <= sq_pn[k-1];
          sq_pd[k] <= sq_pd[k-1];
          sq_s[k]  <= sq_s[k-1];
        end
      end
    end
  end

  // Quadrant fold and trivial-operand detection for one atan2.
  function automatic lane_t pre_lane(input logic signed [NW-1:0] yv,
                                     input logic signed [NW-1:0] xv);
    lane_t                l;
    logic signed [NW-1:0] xa;
    logic signed [NW-1:0] ya;
    logic [NW-1:0]        ma;
    l  = '0;
    xa = xv;
    ya = yv;
    if (xv[NW-1]) begin
      l.base = yv[NW-1] ? -DEG180 : DEG180;
      xa = -xv;
      ya = -yv;
    end
    l.done = (yv == '0);
    ma     = ya[NW-1] ? $unsigned(-ya) : $unsigned(ya);
    l.x    = LW'(xa);
    l.y    = LW'(ya);
    l.mor  = LW'($unsigned(xa) | ma);
    return l;
  endfunction

  logic signed [NW-1:0] c_root;
  lane_t                pre_l [NL];

  assign c_root = NW'({1'b0, sq_r[SQ_STEPS-1][SW-2:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      pre_l[0] <= pre_lane(sq_yn[SQ_STEPS-1], sq_yd[SQ_STEPS-1]);
      pre_l[1] <= pre_lane(sq_pn[SQ_STEPS-1], sq_pd[SQ_STEPS-1]);
      pre_l[2] <= pre_lane(NW'(sq_s[SQ_STEPS-1]), c_root);
    end
  end

  // Normalizer and CORDIC cell rows, one row per lane.
  lane_t nrm_l [NL][NRM_STEPS];
  lane_t cor_l [NL][CORDIC_STAGES];

  for (genvar j = 0; j < NL; j++) begin : g_lane
    for (genvar k = 0; k < NRM_STEPS; k++) begin : g_nrm
      if (k == 0) begin : g_first
        q2e_norm_cell #(.SHIFT(1 << (NRM_STEPS-1-k))) u_cell (
          .clk(clk), .en(en), .d(pre_l[j]), .q(nrm_l[j][k])
        );
      end else begin : g_rest
        q2e_norm_cell #(.SHIFT(1 << (NRM_STEPS-1-k))) u_cell (
          .clk(clk), .en(en), .d(nrm_l[j][k-1]), .q(nrm_l[j][k])
        );
      end
    end
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
      if (k == 0) begin : g_first
        q2e_cordic_cell #(.STAGE(k)) u_cell (
          .clk(clk), .en(en), .d(nrm_l[j][NRM_STEPS-1]), .q(cor_l[j][k])
        );
      end else begin : g_rest
        q2e_cordic_cell #(.STAGE(k)) u_cell (
          .clk(clk), .en(en), .d(cor_l[j][k-1]), .q(cor_l[j][k])
        );
      end
    end
  end

  // Negate the angle; yaw wraps into one full turn.
  logic signed [AW-1:0] a_neg [NL];
  logic signed [AW-1:0] a0    [NL];

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      a_neg[j] = cor_l[j][CORDIC_STAGES-1].done ? -cor_l[j][CORDIC_STAGES-1].base
               : -(cor_l[j][CORDIC_STAGES-1].base + cor_l[j][CORDIC_STAGES-1].z);
    end
    if (a_neg[0][AW-1]) begin
      a_neg[0] = a_neg[0] + DEG360;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= a_neg;
    end
  end

  // Scale by 100.
  logic signed [MW-1:0] m1 [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NL; j++) begin
        m1[j] <= MW'(a0[j]) * SCALE;
      end
    end
  end

  // Truncate toward zero to centidegrees, offset yaw and clamp.
  function automatic logic signed [MW-1:0] clampv(input logic signed [MW-1:0] v,
                                                  input logic signed [MW-1:0] lim);
    logic signed [MW-1:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [MW-1:0] bias [NL];
  logic signed [MW-1:0] cd   [NL];
  logic signed [14:0]   roll_q2;
  logic signed [15:0]   pitch_q2, yaw_q2;
  logic signed [MW-1:0] yaw_off;

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      bias[j] = m1[j] + (m1[j][MW-1] ? RND : ZERO_M);
      cd[j]   = bias[j] >>> 16;
    end
    yaw_off = cd[0] - CD_180;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_q2   <= 16'(clampv(yaw_off, CD_180));
      pitch_q2 <= 16'(clampv(cd[1], CD_180));
      roll_q2  <= 15'(clampv(cd[2], CD_90));
    end
  end

  // Result register with a skid entry behind it.
  logic signed [14:0] skid_roll;
  logic signed [15:0] skid_pitch, skid_yaw;

  always_ff @(posedge clk) begin
    if (rst) begin
      euler_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (!euler_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[NST-1]) begin
      if (euler_valid && euler_stall) begin
        skid_valid <= 1'b1;
      end else begin
        euler_valid <= 1'b1;
      end
    end else if (!euler_stall) begin
      euler_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!euler_stall) begin
        roll_cdeg  <= skid_roll;
        pitch_cdeg <= skid_pitch;
        yaw_cdeg   <= skid_yaw;
      end
    end else if (vld[NST-1]) begin
      if (euler_valid && euler_stall) begin
        skid_roll  <= roll_q2;
        skid_pitch <= pitch_q2;
        skid_yaw   <= yaw_q2;
      end else begin
        roll_cdeg  <= roll_q2;
        pitch_cdeg <= pitch_q2;
        yaw_cdeg   <= yaw_q2;
      end
    end
  end

endmodule

// ===== hw/rtl/q2e_checker.sv =====
// ----------------------------------------------------------------------------
// q2e_port_checks
// Port-level checks for the quaternion to Euler angle core, bound to the
// top level.
// ----------------------------------------------------------------------------
module q2e_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               quat_stall,
  input logic               euler_valid,
  input logic               euler_stall,
  input logic signed [14:0] roll_cdeg,
  input logic signed [15:0] pitch_cdeg,
  input logic signed [15:0] yaw_cdeg
);

  // With no result waiting, the core always takes a beat.
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !euler_valid |-> !quat_stall)
    else $error("input stalled while no result is pending");

  // Input only starts to stall after a result was held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(quat_stall) |-> $past(euler_valid && euler_stall))
    else $error("input stall without a stalled result");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    euler_valid && euler_stall |=> euler_valid && $stable(roll_cdeg) &&
      $stable(pitch_cdeg) && $stable(yaw_cdeg))
    else $error("stalled result beat changed");

  // Delivered angles stay inside their ranges.
  a_range: assert property (@(posedge clk) disable iff (rst)
    euler_valid |-> roll_cdeg >= -15'sd9000 && roll_cdeg <= 15'sd9000 &&
      pitch_cdeg >= -16'sd18000 && pitch_cdeg <= 16'sd18000 &&
      yaw_cdeg >= -16'sd18000 && yaw_cdeg <= 16'sd17999)
    else $error("angle out of range");

  // Nothing is presented right after a reset cycle.
  a_reset: assert property (@(posedge clk) rst |=> !euler_valid)
    else $error("result valid after reset");

endmodule

bind quaternion_to_euler_centidegrees_core q2e_port_checks u_q2e_port_checks (.*);
